// ----- rtl/vsm_pkg.sv -----
// Shared widths, defaults and arithmetic-unit operation codes for the vector softmax.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vsm_pkg;

  localparam int unsigned VEC_LEN_DEF   = 64;
  localparam int unsigned EXP_DEPTH_DEF = 4096;

  localparam int unsigned DATA_W    = 16;  // signed Q4.12 logit
  localparam int unsigned EXP_W     = 16;  // table weight, 65535 stands for 1.0
  localparam int unsigned PROB_W    = 16;  // unsigned Q0.16 result
  localparam int unsigned IDX_SHIFT = 4;   // Q4.12 difference to 1/256 table steps
  localparam int unsigned KEY_W     = DATA_W - IDX_SHIFT;
  localparam int unsigned SUM_W     = 22;  // holds 64 weights of 65535
  localparam int unsigned REM_W     = SUM_W + 1;
  localparam int unsigned QUO_W     = PROB_W + 1;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic signed [DATA_W-1:0] MAX_RESET = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    AOP_HOLD     = 3'd0,
    AOP_CLEAR    = 3'd1,
    AOP_ACC      = 3'd2,
    AOP_DIV_INIT = 3'd3,
    AOP_DIV_STEP = 3'd4
  } aop_e;

endpackage

`default_nettype wire

// ----- rtl/vsm_exp_rom.sv -----
// Exponential weight table exp(-k/256) scaled to 65535, filled once at start-up,
// read through a registered port. Depends on vsm_pkg.
`default_nettype none

module vsm_exp_rom #(
  parameter int unsigned DEPTH = vsm_pkg::EXP_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic [AW-1:0]              addr_i,
  output logic [vsm_pkg::EXP_W-1:0]  data_o
);
  import vsm_pkg::*;

  localparam logic [63:0] M32     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  // Ten terms of the series for exp(-1/256) in Q2.62, each term truncated.
  localparam logic [63:0] T1  = ONE_Q62 / 64'd256;
  localparam logic [63:0] T2  = T1 / 64'd512;
  localparam logic [63:0] T3  = T2 / 64'd768;
  localparam logic [63:0] T4  = T3 / 64'd1024;
  localparam logic [63:0] T5  = T4 / 64'd1280;
  localparam logic [63:0] T6  = T5 / 64'd1536;
  localparam logic [63:0] T7  = T6 / 64'd1792;
  localparam logic [63:0] T8  = T7 / 64'd2048;
  localparam logic [63:0] T9  = T8 / 64'd2304;
  localparam logic [63:0] T10 = T9 / 64'd2560;
  localparam logic [63:0] RATIO = ONE_Q62 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, lo, hi;
    ah  = a >> 32;
    al  = a & M32;
    bh  = b >> 32;
    bl  = b & M32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & M32) + (hl & M32);
    lo  = (ll & M32) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  function automatic logic [EXP_W-1:0] round_scaled(input logic [63:0] v);
    logic [63:0] a, b, r;
    a = 64'd65535 * (v >> 32);
    b = 64'd65535 * (v & M32) + (64'd1 << 61);
    r = (a + (b >> 32)) >> 30;
    return (r > 64'd65535) ? {EXP_W{1'b1}} : r[EXP_W-1:0];
  endfunction

  logic [EXP_W-1:0] rom [DEPTH];

  // Successive powers of the ratio give the table entries in order.
  initial begin : fill_rom
    logic [63:0] v;
    v = ONE_Q62;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      rom[k] = round_scaled(v);
      v      = mul_q62(v, RATIO);
    end
  end

  logic [EXP_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/vsm_store.sv -----
// Element memory for one vector: one write port, one registered read port.
// Depends on vsm_pkg for the element width.
`default_nettype none

module vsm_store #(
  parameter int unsigned VEC_LEN = vsm_pkg::VEC_LEN_DEF,
  parameter int unsigned AW      = $clog2(VEC_LEN)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic signed [vsm_pkg::DATA_W-1:0]  wdata_i,
  input  logic [AW-1:0]                      raddr_i,
  output logic signed [vsm_pkg::DATA_W-1:0]  rdata_o
);
  import vsm_pkg::*;

  logic signed [DATA_W-1:0] mem [VEC_LEN];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/vsm_arith.sv -----
// Shared add/subtract unit: accumulates the weight sum and runs the restoring
// division of weight * 65536 by that sum, one quotient bit a cycle. Depends on vsm_pkg.
`default_nettype none

module vsm_arith (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vsm_pkg::aop_e               op_i,
  input  logic [vsm_pkg::EXP_W-1:0]   exp_i,
  output logic [vsm_pkg::PROB_W-1:0]  probability_o
);
  import vsm_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;

  logic [REM_W-1:0] a_op, b_op;
  logic             sub;
  logic [REM_W:0]   res;
  logic             ge;

  // Operand selection for the single adder.
  always_comb begin
    a_op = {1'b0, sum_q};
    b_op = REM_W'(exp_i);
    sub  = 1'b0;
    case (op_i)
      AOP_DIV_INIT: begin
        a_op = REM_W'(exp_i);
        b_op = {1'b0, sum_q};
        sub  = 1'b1;
      end
      AOP_DIV_STEP: begin
        // The remainder stays below the sum, so the doubled value fits.
        a_op = {rem_q[REM_W-2:0], 1'b0};
        b_op = {1'b0, sum_q};
        sub  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = {1'b0, a_op} + (sub ? ~{1'b0, b_op} : {1'b0, b_op}) + (REM_W + 1)'(sub);
  assign ge  = ~res[REM_W];

  always_comb begin
    sum_d = sum_q;
    rem_d = rem_q;
    quo_d = quo_q;
    case (op_i)
      AOP_CLEAR: sum_d = '0;
      AOP_ACC:   sum_d = res[SUM_W-1:0];
      AOP_DIV_INIT: begin
        // The weight never exceeds the sum, so the top quotient bit is set only
        // when they are equal.
        quo_d = QUO_W'(ge);
        rem_d = ge ? res[REM_W-1:0] : a_op;
      end
      AOP_DIV_STEP: begin
        quo_d = {quo_q[QUO_W-2:0], ge};
        rem_d = ge ? res[REM_W-1:0] : a_op;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign probability_o = quo_q[QUO_W-1] ? {PROB_W{1'b1}} : quo_q[PROB_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/vector_softmax.sv -----
// Max-subtracted softmax over a vector of signed Q4.12 logits, one element per input
// transaction, the last one flagged (or the VEC_LEN-th taken as last). Each element is
// accepted as soon as it is offered while the running maximum is tracked. After the
// last element the block is busy: the weight sum takes a store read, a table read and
// an accumulate per element, then each probability takes an operand fetch (store read,
// table read), the restoring division on the single shared adder (an initial step and
// then one step per quotient bit), and the offer of the result, held for as long as the
// output transaction is held off. Results come out in input order as unsigned Q0.16,
// saturated to 65535, the last one flagged.
// Depends on vsm_pkg, vsm_store, vsm_exp_rom and vsm_arith.
`default_nettype none

module vector_softmax #(
  parameter int unsigned VEC_LEN         = vsm_pkg::VEC_LEN_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = vsm_pkg::EXP_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [vsm_pkg::DATA_W-1:0]  logit_i,
  input  logic                               is_final_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  output logic [vsm_pkg::PROB_W-1:0]         probability_o,
  output logic                               final_out_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import vsm_pkg::*;

  localparam int unsigned IW = $clog2(VEC_LEN);
  localparam int unsigned CW = $clog2(VEC_LEN + 1);
  localparam int unsigned TW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_SUM_RD   = 9'b000000010,
    S_SUM_IDX  = 9'b000000100,
    S_SUM_ACC  = 9'b000001000,
    S_DIV_RD   = 9'b000010000,
    S_DIV_IDX  = 9'b000100000,
    S_DIV_INIT = 9'b001000000,
    S_DIV_STEP = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic signed [DATA_W-1:0] max_q, max_d;
  logic [STEP_W-1:0]        step_q, step_d;
  aop_e                     aop;

  logic                     in_acc, out_acc, last_idx;
  logic signed [DATA_W-1:0] store_rdata;
  logic signed [DATA_W:0]   diff;
  logic [KEY_W-1:0]         key;
  logic [TW-1:0]            rom_addr;
  logic [EXP_W-1:0]         rom_data;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  assign last_idx    = (idx_q == IW'(cnt_q - CW'(1)));
  assign final_out_o = last_idx;

  vsm_store #(
    .VEC_LEN (VEC_LEN),
    .AW      (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (logit_i),
    .raddr_i (idx_q),
    .rdata_o (store_rdata)
  );

  // The difference to the maximum is never negative; its top twelve bits index the
  // table, clamped to the last entry.
  assign diff = {max_q[DATA_W-1], max_q} - {store_rdata[DATA_W-1], store_rdata};
  assign key  = diff[DATA_W-1:IDX_SHIFT];

  always_comb begin
    if (32'(key) > EXP_TABLE_DEPTH - 1) begin
      rom_addr = TW'(EXP_TABLE_DEPTH - 1);
    end else begin
      rom_addr = TW'(key);
    end
  end

  vsm_exp_rom #(
    .DEPTH  (EXP_TABLE_DEPTH),
    .AW     (TW)
  ) u_exp_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  vsm_arith u_arith (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (aop),
    .exp_i         (rom_data),
    .probability_o (probability_o)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    max_d   = max_q;
    step_d  = step_q;
    aop     = AOP_HOLD;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_q + CW'(1);
          if (logit_i > max_q) begin
            max_d = logit_i;
          end
          if (is_final_i || (cnt_q == CW'(VEC_LEN - 1))) begin
            idx_d   = '0;
            aop     = AOP_CLEAR;
            state_d = S_SUM_RD;
          end
        end
      end
      S_SUM_RD:  state_d = S_SUM_IDX;
      S_SUM_IDX: state_d = S_SUM_ACC;
      S_SUM_ACC: begin
        aop = AOP_ACC;
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_DIV_RD;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = S_SUM_RD;
        end
      end
      S_DIV_RD:  state_d = S_DIV_IDX;
      S_DIV_IDX: state_d = S_DIV_INIT;
      S_DIV_INIT: begin
        aop     = AOP_DIV_INIT;
        step_d  = '0;
        state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        aop    = AOP_DIV_STEP;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_idx) begin
            cnt_d   = '0;
            max_d   = MAX_RESET;
            aop     = AOP_CLEAR;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_DIV_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      max_q   <= MAX_RESET;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      max_q   <= max_d;
      step_q  <= step_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output side open at the same time");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_final_i) |=> !in_ready_o)
    else $error("input still open after the closing element");

  a_reopen_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && final_out_o) |=> (in_ready_o && (cnt_q == '0)))
    else $error("block not cleared and open after the final result");

  a_out_has_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("result offered with an empty vector");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for vector_softmax: sends vectors of Q4.12 logits with random idling on both
// channels and checks every probability against a fixed-point softmax predictor (or the
// typed value of a known row). Depends on vsm_pkg and the vector_softmax RTL only.
module testbench;
  import vsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 45;
  localparam int unsigned N_DIRECTED   = 21;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_EXTREME
  } spread_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] logit;
    logic                     is_last;
    logic                     known;
    logic [PROB_W-1:0]        prob;
  } stim_row_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              is_last;
  } prob_item_t;

  // Rows marked known carry the probability that can be read off directly; the rest are
  // checked against the predictor.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{16'sh0000, 1'b1, 1'b1, 16'd65535},  // lone element saturates
    '{16'sh7FFF, 1'b1, 1'b1, 16'd65535},
    '{16'sh8000, 1'b1, 1'b1, 16'd65535},
    '{16'sh7FFF, 1'b0, 1'b1, 16'd65535},  // widest gap: the other weight is negligible
    '{16'sh8000, 1'b1, 1'b1, 16'd0},
    '{16'sd100,  1'b0, 1'b1, 16'd32768},  // two equal weights
    '{16'sd100,  1'b1, 1'b1, 16'd32768},
    '{-16'sd5,   1'b0, 1'b1, 16'd21845},  // three equal weights
    '{-16'sd5,   1'b0, 1'b1, 16'd21845},
    '{-16'sd5,   1'b1, 1'b1, 16'd21845},
    '{16'sd0,    1'b0, 1'b0, 16'd0},
    '{-16'sd16,  1'b0, 1'b0, 16'd0},
    '{-16'sd4096, 1'b0, 1'b0, 16'd0},
    '{16'sd4096, 1'b1, 1'b0, 16'd0},
    '{-16'sd1,   1'b0, 1'b0, 16'd0},
    '{16'sh8000, 1'b0, 1'b0, 16'd0},
    '{16'sd1,    1'b0, 1'b0, 16'd0},
    '{16'sd16,   1'b0, 1'b0, 16'd0},
    '{-16'sd17,  1'b1, 1'b0, 16'd0},
    '{16'sh5555, 1'b0, 1'b0, 16'd0},
    '{16'shAAAA, 1'b1, 1'b0, 16'd0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic signed [DATA_W-1:0] logit_i = '0;
  logic                     is_final_i = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [PROB_W-1:0]        probability_o;
  logic                     final_out_o;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;

  logic [EXP_W-1:0]  exp_weight [EXP_DEPTH_DEF];
  int                vec_elem [VEC_LEN_DEF];
  bit                vec_known [VEC_LEN_DEF];
  logic [PROB_W-1:0] vec_typed [VEC_LEN_DEF];
  int unsigned       vec_count = 0;
  int                vec_max = int'(MAX_RESET);
  prob_item_t        prob_q [$];

  int unsigned       in_accepts = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                gaps_on = 1'b1;
  bit                cur_known = 1'b0;
  logic [PROB_W-1:0] cur_typed = '0;

  vector_softmax dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .logit_i      (logit_i),
    .is_final_i   (is_final_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .probability_o(probability_o),
    .final_out_o  (final_out_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Weights round(65535 * exp(-k/256)): a Q62 ratio exp(-1/256) from a ten-term series,
  // raised step by step with exact truncating products.
  function automatic void build_exp_weights();
    longint unsigned term;
    longint unsigned ratio;
    longint unsigned v;
    logic [127:0]    wide;
    term  = 64'd1 << 62;
    ratio = term;
    v     = term;
    for (int n = 1; n <= 10; n++) begin
      term = term / (64'd256 * n);
      if (n % 2 == 1) ratio = ratio - term;
      else ratio = ratio + term;
    end
    for (int k = 0; k < EXP_DEPTH_DEF; k++) begin
      wide = (128'(v) * 128'd65535 + (128'd1 << 61)) >> 62;
      exp_weight[k] = (wide > 128'd65535) ? 16'hFFFF : wide[15:0];
      wide = 128'(v) * 128'(ratio);
      v = wide[125:62];
    end
  endfunction

  function automatic void emit_vector_probs();
    logic [SUM_W-1:0] sum;
    logic [EXP_W-1:0] w [VEC_LEN_DEF];
    longint unsigned  q;
    int unsigned      idx;
    prob_item_t       item;
    sum = '0;
    for (int i = 0; i < vec_count; i++) begin
      idx = (vec_max - vec_elem[i]) >> IDX_SHIFT;
      if (idx > EXP_DEPTH_DEF - 1) idx = EXP_DEPTH_DEF - 1;
      w[i] = exp_weight[idx];
      sum = sum + w[i];
    end
    for (int i = 0; i < vec_count; i++) begin
      q = (64'(w[i]) << PROB_W) / sum;
      item.prob = (q > 64'd65535) ? '1 : q[PROB_W-1:0];
      if (vec_known[i]) item.prob = vec_typed[i];
      item.is_last = (i == vec_count - 1);
      prob_q.push_back(item);
    end
    vec_count = 0;
    vec_max = int'(MAX_RESET);
  endfunction

  // A vector closes on a flagged element or when the store is full.
  function automatic void take_element(logic signed [DATA_W-1:0] x, logic fin, bit known,
                                       logic [PROB_W-1:0] typed);
    vec_elem[vec_count]  = int'(x);
    vec_known[vec_count] = known;
    vec_typed[vec_count] = typed;
    if (int'(x) > vec_max) vec_max = int'(x);
    vec_count++;
    if (fin || vec_count == VEC_LEN_DEF) emit_vector_probs();
  endfunction

  task automatic report_mismatch(string msg);
    $display("cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    prob_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        take_element(logit_i, is_final_i, cur_known, cur_typed);
        in_accepts++;
      end
      if (out_valid_o && out_ready_i) begin
        if (prob_q.size() == 0) begin
          report_mismatch($sformatf("probability %0d arrived with nothing pending",
                                    probability_o));
        end else begin
          want = prob_q.pop_front();
          if (probability_o !== want.prob)
            report_mismatch($sformatf("probability %0d, expected %0d", probability_o,
                                      want.prob));
          if (final_out_o !== want.is_last)
            report_mismatch($sformatf("last flag %0b, expected %0b", final_out_o,
                                      want.is_last));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Holds the transaction until the monitor has seen it accepted.
  task automatic send_element(logic signed [DATA_W-1:0] x, logic fin, bit known,
                              logic [PROB_W-1:0] typed);
    int unsigned seen;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    logit_i    <= x;
    is_final_i <= fin;
    cur_known  = known;
    cur_typed  = typed;
    seen = in_accepts;
    do @(negedge clk_i); while (in_accepts == seen);
  endtask

  task automatic send_random_vector(int unsigned len, bit close_it);
    spread_e                  spread;
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] x;
    spread = spread_e'($urandom_range(SPREAD_EXTREME));
    base   = 16'($urandom_range(65535));
    for (int i = 0; i < len; i++) begin
      case (spread)
        SPREAD_FULL: begin
          x = 16'($urandom_range(65535));
        end
        SPREAD_NARROW: begin
          x = 16'(base + $urandom_range(4096) - 2048);
        end
        default: begin
          case ($urandom_range(3))
            0: x = 16'sh7FFF;
            1: x = 16'sh8000;
            2: x = 16'sh0000;
            default: x = 16'($urandom_range(65535));
          endcase
        end
      endcase
      send_element(x, close_it && (i == len - 1), 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    build_exp_weights();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r])
      send_element(directed_rows[r].logit, directed_rows[r].is_last,
                   directed_rows[r].known, directed_rows[r].prob);

    // An unflagged vector that fills the store and closes on its own.
    send_random_vector(VEC_LEN_DEF, 1'b0);

    // Let the block drain completely before the next vector.
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (prob_q.size() != 0) @(negedge clk_i);

    sent = 0;
    for (int v = 0; sent < RANDOM_ITEMS; v++) begin
      gaps_on = !(v >= 4 && v < 9);
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
      send_random_vector(len, 1'b1);
      sent += len;
    end
    gaps_on = 1'b1;

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (prob_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
